@@ rtl/rrps_pkg.sv @@
// Shared types, constants and helper functions for the round-robin process scheduler.
// Depends on nothing; every other file of the block refers to it by scoped names.
package rrps_pkg;

  localparam int MaxProcs = 16;
  localparam int IdxW = $clog2(MaxProcs);
  localparam int CntW = IdxW + 1;

  localparam logic [2:0] KIND_ADMIT = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_TIMESLICE = 3'd2;
  localparam logic [2:0] KIND_SYSCALL = 3'd3;
  localparam logic [2:0] KIND_IO_DONE = 3'd4;
  localparam logic [2:0] KIND_EXIT = 3'd5;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_TERMINATED = 2'd3;

  typedef struct packed {
    logic load;
    logic dispatch;
    logic io_pop;
    logic sched_pop;
    logic sched_chk;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic disp_iopop;
    logic disp_sched;
    logic pop_ok;
    logic chk_dead;
  } sts_t;

  // Clamps the process count register to the range 1 to MaxProcs.
  function automatic logic [CntW-1:0] sat_count(input logic [CntW-1:0] raw);
    logic [CntW-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = CntW'(1);
    end else if (raw > CntW'(MaxProcs)) begin
      res = CntW'(MaxProcs);
    end
    return res;
  endfunction

  // Moves a ring pointer by one place and wraps it at the process count.
  function automatic logic [IdxW-1:0] advance(input logic [IdxW-1:0] p,
                                               input logic [CntW-1:0] n);
    logic [CntW-1:0] q;
    q = {1'b0, p} + CntW'(1);
    return (q >= n) ? '0 : q[IdxW-1:0];
  endfunction

endpackage

@@ rtl/rrps_ctrl.sv @@
// Controller state machine of the round-robin process scheduler.
// Depends on rrps_pkg for the command and status structs.
module rrps_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rrps_pkg::sts_t sts_i,
  output rrps_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DISPATCH  = 6'b000010,
    S_IO_POP    = 6'b000100,
    S_SCHED     = 6'b001000,
    S_SCHED_CHK = 6'b010000,
    S_FINISH    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd_o.dispatch = 1'b1;
        if (sts_i.disp_iopop) begin
          state_d = S_IO_POP;
        end else if (sts_i.disp_sched) begin
          state_d = S_SCHED;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_IO_POP: begin
        cmd_o.io_pop = 1'b1;
        state_d = S_SCHED;
      end
      S_SCHED: begin
        cmd_o.sched_pop = 1'b1;
        state_d = sts_i.pop_ok ? S_SCHED_CHK : S_FINISH;
      end
      S_SCHED_CHK: begin
        cmd_o.sched_chk = 1'b1;
        state_d = sts_i.chk_dead ? S_SCHED : S_FINISH;
      end
      S_FINISH: begin
        cmd_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rrps_datapath.sv @@
// Datapath of the round-robin process scheduler: process table, ready and blocked rings,
// counters and result registers. Depends on rrps_pkg.
module rrps_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rrps_pkg::cmd_t                cmd_i,
  output rrps_pkg::sts_t                sts_o,
  input  logic [rrps_pkg::CntW-1:0]     num_proc_i,
  input  logic [2:0]                    kind_i,
  input  logic [rrps_pkg::IdxW-1:0]     proc_index_i,
  input  logic signed [31:0]            pc_value_i,
  output logic                          done_o,
  output logic                          stopped_valid_o,
  output logic [rrps_pkg::IdxW-1:0]     stopped_index_o,
  output logic                          started_valid_o,
  output logic                          running_valid_o,
  output logic [rrps_pkg::IdxW-1:0]     running_index_o,
  output logic                          io_request_o,
  output logic                          all_done_o,
  output logic                          event_ignored_o
);

  localparam int IdxW = rrps_pkg::IdxW;
  localparam int CntW = rrps_pkg::CntW;
  localparam int MaxProcs = rrps_pkg::MaxProcs;

  logic [2:0]             kind_q, kind_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic signed [31:0]     pc_q, pc_d;

  logic [1:0]             status_q [MaxProcs];
  logic signed [31:0]     pc_mem [MaxProcs];
  logic [IdxW-1:0]        rring [MaxProcs];
  logic [IdxW-1:0]        bring [MaxProcs];
  logic [IdxW-1:0]        rring_rd_q, bring_rd_q;

  logic [IdxW-1:0]        rhead_q, rhead_d, rtail_q, rtail_d;
  logic [IdxW-1:0]        bhead_q, bhead_d, btail_q, btail_d;
  logic [CntW-1:0]        rcount_q, rcount_d, bcount_q, bcount_d;
  logic                   hr_q, hr_d;
  logic [IdxW-1:0]        cur_q, cur_d;
  logic [CntW-1:0]        term_q, term_d;
  logic [CntW-1:0]        guard_q, guard_d;

  logic                   stop_q, stop_d;
  logic [IdxW-1:0]        stop_idx_q, stop_idx_d;
  logic                   started_q, started_d;
  logic                   io_q, io_d;
  logic                   ign_q, ign_d;
  logic                   valid_q;

  logic                   st_we;
  logic [IdxW-1:0]        st_waddr;
  logic [1:0]             st_wdata;
  logic [IdxW-1:0]        st_raddr;
  logic [1:0]             st_rd;
  logic                   r_we, r_re, b_we, b_re, pc_we;
  logic [IdxW-1:0]        r_wdata;
  logic                   slot_ok, rpush_ok, bpush_ok;

  assign slot_ok = ({1'b0, idx_q} < num_proc_i);
  assign rpush_ok = (rcount_q < num_proc_i);
  assign bpush_ok = (bcount_q < num_proc_i);

  always_comb begin
    priority if (cmd_i.io_pop) begin
      st_raddr = bring_rd_q;
    end else if (cmd_i.sched_chk) begin
      st_raddr = rring_rd_q;
    end else begin
      st_raddr = idx_q;
    end
  end

  assign st_rd = status_q[st_raddr];

  always_comb begin
    sts_o.disp_iopop = (kind_q == rrps_pkg::KIND_IO_DONE) && (bcount_q != '0);
    sts_o.disp_sched = ((kind_q == rrps_pkg::KIND_START) && !hr_q)
                    || (((kind_q == rrps_pkg::KIND_TIMESLICE)
                      || (kind_q == rrps_pkg::KIND_SYSCALL)) && hr_q)
                    || ((kind_q == rrps_pkg::KIND_EXIT) && slot_ok
                      && (st_rd != rrps_pkg::ST_TERMINATED) && hr_q && (cur_q == idx_q));
    sts_o.pop_ok = !hr_q && (guard_q != CntW'(MaxProcs)) && (rcount_q != '0);
    sts_o.chk_dead = (st_rd == rrps_pkg::ST_TERMINATED);
  end

  always_comb begin
    kind_d = kind_q;
    idx_d = idx_q;
    pc_d = pc_q;
    rhead_d = rhead_q;
    rtail_d = rtail_q;
    bhead_d = bhead_q;
    btail_d = btail_q;
    rcount_d = rcount_q;
    bcount_d = bcount_q;
    hr_d = hr_q;
    cur_d = cur_q;
    term_d = term_q;
    guard_d = guard_q;
    stop_d = stop_q;
    stop_idx_d = stop_idx_q;
    started_d = started_q;
    io_d = io_q;
    ign_d = ign_q;
    st_we = 1'b0;
    st_waddr = idx_q;
    st_wdata = rrps_pkg::ST_READY;
    r_we = 1'b0;
    r_re = 1'b0;
    r_wdata = idx_q;
    b_we = 1'b0;
    b_re = 1'b0;
    pc_we = 1'b0;

    if (cmd_i.load) begin
      kind_d = kind_i;
      idx_d = proc_index_i;
      pc_d = pc_value_i;
      stop_d = 1'b0;
      stop_idx_d = '0;
      started_d = 1'b0;
      io_d = 1'b0;
      ign_d = 1'b0;
      guard_d = '0;
    end

    if (cmd_i.dispatch) begin
      unique case (kind_q)
        rrps_pkg::KIND_ADMIT: begin
          if (!slot_ok || (st_rd == rrps_pkg::ST_RUNNING)
              || (st_rd == rrps_pkg::ST_BLOCKED)) begin
            ign_d = 1'b1;
          end else begin
            if ((st_rd == rrps_pkg::ST_TERMINATED) && (term_q != '0)) begin
              term_d = term_q - CntW'(1);
            end
            st_we = 1'b1;
            st_waddr = idx_q;
            st_wdata = rrps_pkg::ST_READY;
            if (rpush_ok) begin
              r_we = 1'b1;
              r_wdata = idx_q;
              rtail_d = rrps_pkg::advance(rtail_q, num_proc_i);
              rcount_d = rcount_q + CntW'(1);
            end
          end
        end
        rrps_pkg::KIND_START: begin
          ign_d = hr_q;
        end
        rrps_pkg::KIND_TIMESLICE: begin
          if (!hr_q) begin
            ign_d = 1'b1;
          end else begin
            stop_d = 1'b1;
            stop_idx_d = cur_q;
            st_we = 1'b1;
            st_waddr = cur_q;
            st_wdata = rrps_pkg::ST_READY;
            if (rpush_ok) begin
              r_we = 1'b1;
              r_wdata = cur_q;
              rtail_d = rrps_pkg::advance(rtail_q, num_proc_i);
              rcount_d = rcount_q + CntW'(1);
            end
            hr_d = 1'b0;
          end
        end
        rrps_pkg::KIND_SYSCALL: begin
          if (!hr_q) begin
            ign_d = 1'b1;
          end else begin
            stop_d = 1'b1;
            stop_idx_d = cur_q;
            pc_we = 1'b1;
            st_we = 1'b1;
            st_waddr = cur_q;
            st_wdata = rrps_pkg::ST_BLOCKED;
            if (bpush_ok) begin
              b_we = 1'b1;
              btail_d = rrps_pkg::advance(btail_q, num_proc_i);
              bcount_d = bcount_q + CntW'(1);
              io_d = (bcount_q == '0);
            end
            hr_d = 1'b0;
          end
        end
        rrps_pkg::KIND_IO_DONE: begin
          if (bcount_q == '0) begin
            ign_d = 1'b1;
          end else begin
            b_re = 1'b1;
            bhead_d = rrps_pkg::advance(bhead_q, num_proc_i);
            bcount_d = bcount_q - CntW'(1);
            io_d = (bcount_q != CntW'(1));
          end
        end
        rrps_pkg::KIND_EXIT: begin
          if (!slot_ok || (st_rd == rrps_pkg::ST_TERMINATED)) begin
            ign_d = 1'b1;
          end else begin
            st_we = 1'b1;
            st_waddr = idx_q;
            st_wdata = rrps_pkg::ST_TERMINATED;
            term_d = term_q + CntW'(1);
            if (hr_q && (cur_q == idx_q)) begin
              hr_d = 1'b0;
            end
          end
        end
        default: begin
          ign_d = 1'b1;
        end
      endcase
    end

    if (cmd_i.io_pop) begin
      if (st_rd != rrps_pkg::ST_TERMINATED) begin
        st_we = 1'b1;
        st_waddr = bring_rd_q;
        st_wdata = rrps_pkg::ST_READY;
        if (rpush_ok) begin
          r_we = 1'b1;
          r_wdata = bring_rd_q;
          rtail_d = rrps_pkg::advance(rtail_q, num_proc_i);
          rcount_d = rcount_q + CntW'(1);
        end
      end
    end

    if (cmd_i.sched_pop && sts_o.pop_ok) begin
      r_re = 1'b1;
      rhead_d = rrps_pkg::advance(rhead_q, num_proc_i);
      rcount_d = rcount_q - CntW'(1);
      guard_d = guard_q + CntW'(1);
    end

    if (cmd_i.sched_chk && (st_rd != rrps_pkg::ST_TERMINATED)) begin
      hr_d = 1'b1;
      cur_d = rring_rd_q;
      st_we = 1'b1;
      st_waddr = rring_rd_q;
      st_wdata = rrps_pkg::ST_RUNNING;
      started_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxProcs; i++) begin
        status_q[i] <= rrps_pkg::ST_READY;
      end
    end else if (st_we) begin
      status_q[st_waddr] <= st_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_we) begin
      rring[rtail_q] <= r_wdata;
    end
    if (r_re) begin
      rring_rd_q <= rring[rhead_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bring[btail_q] <= cur_q;
    end
    if (b_re) begin
      bring_rd_q <= bring[bhead_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pc_we) begin
      pc_mem[cur_q] <= pc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rhead_q <= '0;
      rtail_q <= '0;
      bhead_q <= '0;
      btail_q <= '0;
      rcount_q <= '0;
      bcount_q <= '0;
      hr_q <= 1'b0;
      cur_q <= '0;
      term_q <= '0;
      guard_q <= '0;
      stop_q <= 1'b0;
      started_q <= 1'b0;
      io_q <= 1'b0;
      ign_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      rhead_q <= rhead_d;
      rtail_q <= rtail_d;
      bhead_q <= bhead_d;
      btail_q <= btail_d;
      rcount_q <= rcount_d;
      bcount_q <= bcount_d;
      hr_q <= hr_d;
      cur_q <= cur_d;
      term_q <= term_d;
      guard_q <= guard_d;
      stop_q <= stop_d;
      started_q <= started_d;
      io_q <= io_d;
      ign_q <= ign_d;
      valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    idx_q <= idx_d;
    pc_q <= pc_d;
    stop_idx_q <= stop_idx_d;
    if (cmd_i.emit) begin
      stopped_valid_o <= stop_q;
      stopped_index_o <= stop_q ? stop_idx_q : '0;
      started_valid_o <= started_q;
      running_valid_o <= hr_q;
      running_index_o <= hr_q ? cur_q : '0;
      io_request_o <= io_q;
      all_done_o <= (term_q >= num_proc_i);
      event_ignored_o <= ign_q || ((kind_q == rrps_pkg::KIND_START) && !started_q);
    end
  end

  assign done_o = valid_q;

endmodule

@@ rtl/round_robin_process_scheduler.sv @@
// Top level of the round-robin process scheduler: configuration register and the
// controller and datapath. Depends on rrps_pkg, rrps_ctrl and rrps_datapath.
//
// An item is taken when start is high and busy is low, and its single result appears
// on the result ports for one cycle with done_o high. The receiver cannot stall the
// block. An item that needs no scheduling passes the dispatch and finish states after
// it is taken; an I/O done event adds the I/O pop state, and each ready-ring entry
// the scheduler examines adds the pop state, for the registered read of the ready-ring
// memory, and the check state, for the status of the popped process. A scheduling pass
// that ends without dispatching a live process adds one more pop state. The worst case
// is the whole ready ring holding terminated processes, as a pass examines at most
// MaxProcs entries. The busy output drops in the cycle the result shows, so the next
// item can be taken at the edge that accepts the result. The process count register
// must be written only while the block is idle.
module round_robin_process_scheduler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                kind_i,
  input  logic [rrps_pkg::IdxW-1:0] proc_index_i,
  input  logic signed [31:0]        pc_value_i,
  output logic                      done_o,
  output logic                      stopped_valid_o,
  output logic [rrps_pkg::IdxW-1:0] stopped_index_o,
  output logic                      started_valid_o,
  output logic                      running_valid_o,
  output logic [rrps_pkg::IdxW-1:0] running_index_o,
  output logic                      io_request_o,
  output logic                      all_done_o,
  output logic                      event_ignored_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [rrps_pkg::CntW-1:0] num_q, num_d;
  logic [rrps_pkg::CntW-1:0] num_sat;
  logic                      cfg_we;
  rrps_pkg::cmd_t            cmd;
  rrps_pkg::sts_t            sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign num_d = cfg_we ? pwdata[rrps_pkg::CntW-1:0] : num_q;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - rrps_pkg::CntW){1'b0}}, num_q};
  assign num_sat = rrps_pkg::sat_count(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= rrps_pkg::CntW'(1);
    end else begin
      num_q <= num_d;
    end
  end

  rrps_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  rrps_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .num_proc_i      (num_sat),
    .kind_i          (kind_i),
    .proc_index_i    (proc_index_i),
    .pc_value_i      (pc_value_i),
    .done_o          (done_o),
    .stopped_valid_o (stopped_valid_o),
    .stopped_index_o (stopped_index_o),
    .started_valid_o (started_valid_o),
    .running_valid_o (running_valid_o),
    .running_index_o (running_index_o),
    .io_request_o    (io_request_o),
    .all_done_o      (all_done_o),
    .event_ignored_o (event_ignored_o)
  );

endmodule
